@@ src/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the priority periodic task dispatcher.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int TASK_W = 8;
    localparam int TIME_W = 32;
    localparam int PRIO_W = 8;
    localparam int FUNC_W = 2;
    localparam int KIND_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_RUN   = 2'd2
    } ppd_func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED      = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_DISPATCHED = 3'd2,
        KIND_NONE_DUE   = 3'd3,
        KIND_CLEARED    = 3'd4
    } ppd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_RUN,
        ST_DONE
    } ppd_state_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] period;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] last_run;
    } ppd_slot_t;

    typedef struct packed {
        ppd_func_t         func;
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] period;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] now;
    } ppd_item_t;

    typedef struct packed {
        logic load;
        logic add_step;
        logic add_commit;
        logic run_step;
        logic finish_push;
    } ppd_cmd_t;

    typedef struct packed {
        logic full;
        logic head_due;
        logic pend_valid;
        logic can_push;
    } ppd_sts_t;

endpackage

@@ src/ppd_in_if.sv @@
// ----------------------------------------------------------------------------
// ppd_in_if
// Request channel: operation code and task / time fields.
// ----------------------------------------------------------------------------
interface ppd_in_if;
    logic                          valid;
    logic                          ready;
    logic [ppd_pkg::FUNC_W-1:0]    func;
    logic [ppd_pkg::TASK_W-1:0]    task_id;
    logic [ppd_pkg::TIME_W-1:0]    period;
    logic [ppd_pkg::PRIO_W-1:0]    priority_req;
    logic [ppd_pkg::TIME_W-1:0]    now;

    modport source (output valid, func, task_id, period, priority_req, now, input ready);
    modport sink   (input valid, func, task_id, period, priority_req, now, output ready);
endinterface

@@ src/ppd_out_if.sv @@
// ----------------------------------------------------------------------------
// ppd_out_if
// Result channel: result kind, dispatched task id and last marker.
// ----------------------------------------------------------------------------
interface ppd_out_if;
    logic                          valid;
    logic                          ready;
    logic [ppd_pkg::KIND_W-1:0]    kind;
    logic [ppd_pkg::TASK_W-1:0]    dispatched_id;
    logic                          last;

    modport source (output valid, kind, dispatched_id, last, input ready);
    modport sink   (input valid, kind, dispatched_id, last, output ready);
endinterface

@@ src/priority_periodic_task_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// priority_periodic_task_dispatcher_top
// Periodic task table kept in priority order; dispatches due tasks on run.
//
//   channel  dir  fields                                       results/item
//   in_ch    in   func, task_id, period, priority_req, now     -
//   out_ch   out  kind, dispatched_id, last                    0 .. TASK_SLOTS
//
// Clear and a rejected add: no table pass, straight to the final result.
// Add and run: TASK_SLOTS ring steps, one slot a cycle unless a run stalls.
// Unused operation code: taken, no result.
// A run stalls while a due task waits and the result register is still full.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module priority_periodic_task_dispatcher_top #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    ppd_in_if.sink      in_ch,
    ppd_out_if.source   out_ch
);

    ppd_pkg::ppd_item_t  item;
    ppd_pkg::ppd_cmd_t   cmd;
    ppd_pkg::ppd_sts_t   sts;
    ppd_pkg::ppd_kind_t  out_kind;

    assign item.func    = ppd_pkg::ppd_func_t'(in_ch.func);
    assign item.task_id = in_ch.task_id;
    assign item.period  = in_ch.period;
    assign item.prio    = in_ch.priority_req;
    assign item.now     = in_ch.now;

    ppd_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (item.func),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppd_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .out_valid (out_ch.valid),
        .out_kind  (out_kind),
        .out_id    (out_ch.dispatched_id),
        .out_last  (out_ch.last)
    );

    assign out_ch.kind = out_kind;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready &&
         (item.func == ppd_pkg::FUNC_CLEAR || item.func == ppd_pkg::FUNC_ADD ||
          item.func == ppd_pkg::FUNC_RUN)) |=> !in_ch.ready)
        else $error("request taken while previous one still in work");

    a_finish_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_push |=> (out_ch.valid && out_ch.last))
        else $error("final result not presented with last set");

    a_single_result_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_kind != ppd_pkg::KIND_DISPATCHED) |->
        (out_ch.last && out_ch.dispatched_id == '0))
        else $error("non-dispatch result without last or with nonzero id");

    a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add_step || cmd.run_step) |-> !in_ch.ready)
        else $error("input ready during table pass");

endmodule

@@ src/ppd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppd_ctrl
// Sequencer: accepts a request, runs one table pass of TASK_SLOTS steps for
// add (when the table has room) and run, then hands off the final result.
// ----------------------------------------------------------------------------
module ppd_ctrl #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ppd_pkg::ppd_func_t  in_func,
    output logic                in_ready,
    input  ppd_pkg::ppd_sts_t   sts,
    output ppd_pkg::ppd_cmd_t   cmd
);

    localparam int STEP_W = $clog2(TASK_SLOTS + 1);

    ppd_pkg::ppd_state_t state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                last_step;

    assign last_step = (step_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppd_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_func)
                        ppd_pkg::FUNC_CLEAR: state_next = ppd_pkg::ST_DONE;
                        ppd_pkg::FUNC_ADD:   state_next = sts.full ? ppd_pkg::ST_DONE
                                                                   : ppd_pkg::ST_ADD;
                        ppd_pkg::FUNC_RUN:   state_next = ppd_pkg::ST_RUN;
                        default:             state_next = ppd_pkg::ST_IDLE;
                    endcase
                end
            end
            ppd_pkg::ST_ADD:
            begin
                if (last_step)
                    state_next = ppd_pkg::ST_DONE;
            end
            ppd_pkg::ST_RUN:
            begin
                if (cmd.run_step && last_step)
                    state_next = ppd_pkg::ST_DONE;
            end
            ppd_pkg::ST_DONE:
            begin
                if (sts.can_push)
                    state_next = ppd_pkg::ST_IDLE;
            end
            default: state_next = ppd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        step_next = step_reg;
        unique case (state_reg)
            ppd_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid;
                step_next = STEP_W'(TASK_SLOTS - 1);
            end
            ppd_pkg::ST_ADD:
            begin
                cmd.add_step   = 1'b1;
                cmd.add_commit = last_step;
                step_next      = step_reg - 1'b1;
            end
            ppd_pkg::ST_RUN:
            begin
                // hold the ring while a due task waits behind a full output
                cmd.run_step = !(sts.head_due && sts.pend_valid && !sts.can_push);
                if (cmd.run_step)
                    step_next = step_reg - 1'b1;
            end
            ppd_pkg::ST_DONE:
            begin
                cmd.finish_push = sts.can_push;
            end
            default: ;
        endcase
    end

endmodule

@@ src/ppd_datapath.sv @@
// ----------------------------------------------------------------------------
// ppd_datapath
// Task table as a rotating ring of slots, insert carry, due check on the
// head slot, pending dispatch holder and result register.
// ----------------------------------------------------------------------------
module ppd_datapath #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ppd_pkg::ppd_item_t                 item,
    input  ppd_pkg::ppd_cmd_t                  cmd,
    input  logic                               out_ready,
    output ppd_pkg::ppd_sts_t                  sts,
    output logic                               out_valid,
    output ppd_pkg::ppd_kind_t                 out_kind,
    output logic [ppd_pkg::TASK_W-1:0]         out_id,
    output logic                               out_last
);

    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    // table ring: slot 0 is the head, slot TASK_SLOTS-1 takes the tail
    logic [TASK_SLOTS-1:0]         valid_reg;
    ppd_pkg::ppd_slot_t            slot_reg [TASK_SLOTS];
    ppd_pkg::ppd_slot_t            carry_reg;
    logic                          carry_valid_reg;
    logic                          placed_reg;
    logic [CNT_W-1:0]              count_reg;

    logic [ppd_pkg::TASK_W-1:0]    id_reg;
    logic [ppd_pkg::TIME_W-1:0]    period_reg;
    logic [ppd_pkg::PRIO_W-1:0]    prio_reg;
    logic [ppd_pkg::TIME_W-1:0]    now_reg;

    logic                          pend_valid_reg;
    logic [ppd_pkg::TASK_W-1:0]    pend_id_reg;
    ppd_pkg::ppd_kind_t            fin_kind_reg;

    logic                          out_valid_reg;
    ppd_pkg::ppd_kind_t            out_kind_reg;
    logic [ppd_pkg::TASK_W-1:0]    out_id_reg;
    logic                          out_last_reg;

    ppd_pkg::ppd_slot_t            head;
    ppd_pkg::ppd_slot_t            new_slot;
    ppd_pkg::ppd_slot_t            tail_slot;
    logic                          head_valid;
    logic                          tail_valid;
    logic [ppd_pkg::TIME_W-1:0]    elapsed;
    logic                          head_due;
    logic                          place;
    logic                          shift;
    logic                          clear_now;
    logic                          full;
    logic                          can_push;
    logic                          push_mid;

    assign head       = slot_reg[0];
    assign head_valid = valid_reg[0];
    assign elapsed    = now_reg - head.last_run;
    assign head_due   = head_valid && (elapsed >= head.period);
    assign place      = !placed_reg && (!head_valid || (head.prio < prio_reg));
    assign shift      = cmd.add_step || cmd.run_step;
    assign clear_now  = cmd.load && (item.func == ppd_pkg::FUNC_CLEAR);
    assign full       = (count_reg == CNT_W'(TASK_SLOTS));
    assign can_push   = !out_valid_reg || out_ready;
    assign push_mid   = cmd.run_step && head_due && pend_valid_reg;

    assign new_slot.task_id  = id_reg;
    assign new_slot.period   = period_reg;
    assign new_slot.prio     = prio_reg;
    assign new_slot.last_run = '0;

    always_comb
    begin
        tail_slot  = head;
        tail_valid = head_valid;
        if (cmd.add_step)
        begin
            if (place)
            begin
                tail_slot  = new_slot;
                tail_valid = 1'b1;
            end
            else if (placed_reg)
            begin
                tail_slot  = carry_reg;
                tail_valid = carry_valid_reg;
            end
        end
        if (cmd.run_step && head_due)
            tail_slot.last_run = now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            carry_valid_reg <= 1'b0;
            placed_reg      <= 1'b0;
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            fin_kind_reg    <= ppd_pkg::KIND_NONE_DUE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clear_now)
                valid_reg <= '0;
            else if (shift)
            begin
                for (int i = 0; i < TASK_SLOTS - 1; i++)
                    valid_reg[i] <= valid_reg[i+1];
                valid_reg[TASK_SLOTS-1] <= tail_valid;
            end

            if (cmd.load)
            begin
                carry_valid_reg <= 1'b0;
                placed_reg      <= 1'b0;
            end
            else if (cmd.add_step && (place || placed_reg))
            begin
                carry_valid_reg <= head_valid;
                placed_reg      <= 1'b1;
            end

            if (clear_now)
                count_reg <= '0;
            else if (cmd.add_commit)
                count_reg <= count_reg + 1'b1;

            if (cmd.load)
            begin
                case (item.func)
                    ppd_pkg::FUNC_CLEAR: fin_kind_reg <= ppd_pkg::KIND_CLEARED;
                    ppd_pkg::FUNC_ADD:   fin_kind_reg <= full ? ppd_pkg::KIND_FULL
                                                              : ppd_pkg::KIND_ADDED;
                    default:             fin_kind_reg <= ppd_pkg::KIND_NONE_DUE;
                endcase
            end

            if (cmd.load || cmd.finish_push)
                pend_valid_reg <= 1'b0;
            else if (cmd.run_step && head_due)
                pend_valid_reg <= 1'b1;

            if (push_mid || cmd.finish_push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < TASK_SLOTS - 1; i++)
                slot_reg[i] <= slot_reg[i+1];
            slot_reg[TASK_SLOTS-1] <= tail_slot;
        end

        if (cmd.add_step && (place || placed_reg))
            carry_reg <= head;

        if (cmd.load)
        begin
            id_reg     <= item.task_id;
            period_reg <= item.period;
            prio_reg   <= item.prio;
            now_reg    <= item.now;
        end

        if (cmd.run_step && head_due)
            pend_id_reg <= head.task_id;

        if (push_mid)
        begin
            out_kind_reg <= ppd_pkg::KIND_DISPATCHED;
            out_id_reg   <= pend_id_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.finish_push)
        begin
            out_kind_reg <= pend_valid_reg ? ppd_pkg::KIND_DISPATCHED : fin_kind_reg;
            out_id_reg   <= pend_valid_reg ? pend_id_reg : '0;
            out_last_reg <= 1'b1;
        end
    end

    assign sts.full       = full;
    assign sts.head_due   = head_due;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.can_push   = can_push;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority periodic task dispatcher. Requests go
// in through a valid/ready channel with random gaps. A local copy of the task
// table predicts the result stream: insert order, the full table, due tests
// with 32-bit wrap, and the last marker. Every result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TASK_SLOTS  = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int FUNC_W      = ppd_pkg::FUNC_W;
    localparam int TASK_W      = ppd_pkg::TASK_W;
    localparam int TIME_W      = ppd_pkg::TIME_W;
    localparam int PRIO_W      = ppd_pkg::PRIO_W;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        ppd_pkg::ppd_kind_t kind;
        logic [TASK_W-1:0]  id;
        logic               last;
    } result_t;

    logic clk;
    logic rst_n;

    ppd_in_if  in_ch ();
    ppd_out_if out_ch ();

    priority_periodic_task_dispatcher_top #(
        .TASK_SLOTS(TASK_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // task table as the block should hold it; occupied entries at the front
    logic [TASK_W-1:0] tbl_id     [TASK_SLOTS];
    logic [TIME_W-1:0] tbl_period [TASK_SLOTS];
    logic [PRIO_W-1:0] tbl_prio   [TASK_SLOTS];
    logic [TIME_W-1:0] tbl_last   [TASK_SLOTS];
    int                tbl_count;

    result_t pending_results[$];
    int      mismatch_count;
    int      req_count;
    bit      no_idle;
    bit      hold_req;
    logic [TIME_W-1:0] tick;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void predict_results(input logic [FUNC_W-1:0] func,
                                            input logic [TASK_W-1:0] id,
                                            input logic [TIME_W-1:0] period,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic [TIME_W-1:0] now);
        int                pos;
        int                hits;
        result_t           r;
        logic [TIME_W-1:0] elapsed;
        pos  = 0;
        hits = 0;
        if (func == ppd_pkg::FUNC_CLEAR)
        begin
            tbl_count = 0;
            pending_results.push_back('{ppd_pkg::KIND_CLEARED, '0, 1'b1});
        end
        else if (func == ppd_pkg::FUNC_ADD)
        begin
            if (tbl_count >= TASK_SLOTS)
            begin
                pending_results.push_back('{ppd_pkg::KIND_FULL, '0, 1'b1});
            end
            else
            begin
                while (pos < tbl_count && tbl_prio[pos] >= prio)
                    pos++;
                for (int j = tbl_count; j > pos; j--)
                begin
                    tbl_id[j]     = tbl_id[j-1];
                    tbl_period[j] = tbl_period[j-1];
                    tbl_prio[j]   = tbl_prio[j-1];
                    tbl_last[j]   = tbl_last[j-1];
                end
                tbl_id[pos]     = id;
                tbl_period[pos] = period;
                tbl_prio[pos]   = prio;
                tbl_last[pos]   = '0;
                tbl_count++;
                pending_results.push_back('{ppd_pkg::KIND_ADDED, '0, 1'b1});
            end
        end
        else if (func == ppd_pkg::FUNC_RUN)
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                elapsed = now - tbl_last[i];
                if (elapsed >= tbl_period[i])
                begin
                    pending_results.push_back('{ppd_pkg::KIND_DISPATCHED, tbl_id[i], 1'b0});
                    tbl_last[i] = now;
                    hits++;
                end
            end
            if (hits == 0)
            begin
                pending_results.push_back('{ppd_pkg::KIND_NONE_DUE, '0, 1'b1});
            end
            else
            begin
                r = pending_results.pop_back();
                r.last = 1'b1;
                pending_results.push_back(r);
            end
        end
    endfunction

    task automatic send_req(input logic [FUNC_W-1:0] func,
                            input logic [TASK_W-1:0] id,
                            input logic [TIME_W-1:0] period,
                            input logic [PRIO_W-1:0] prio,
                            input logic [TIME_W-1:0] now);
        while (!no_idle && $urandom_range(99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= func;
        in_ch.task_id      <= id;
        in_ch.period       <= period;
        in_ch.priority_req <= prio;
        in_ch.now          <= now;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        predict_results(func, id, period, prio, now);
        if (func != FUNC_UNUSED)
            req_count++;
    endtask

    // result checker
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d id %0d last %0d", $time,
                             out_ch.kind, out_ch.dispatched_id, out_ch.last);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.kind !== want.kind)
                    begin
                        $display("%0t: kind exp %0d act %0d", $time, want.kind, out_ch.kind);
                        mismatch_count++;
                    end
                    if (out_ch.dispatched_id !== want.id)
                    begin
                        $display("%0t: dispatched_id exp %0d act %0d", $time, want.id,
                                 out_ch.dispatched_id);
                        mismatch_count++;
                    end
                    if (out_ch.last !== want.last)
                    begin
                        $display("%0t: last exp %0d act %0d", $time, want.last, out_ch.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // result sink: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            out_ch.ready <= no_idle || ($urandom_range(99) >= 21);
        end
    end

    function automatic logic [TIME_W-1:0] rand_period();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return '0;
        else if (pick < 30)
            return TIME_W'($urandom);
        else
            return TIME_W'($urandom_range(20));
    endfunction

    function automatic logic [PRIO_W-1:0] rand_prio();
        if ($urandom_range(1))
            return PRIO_W'($urandom_range(3));
        else
            return PRIO_W'($urandom_range(255));
    endfunction

    // usually clear, random adds, runs at mostly rising times, or one request
    task automatic random_schedule();
        int n_add;
        int n_run;
        if ($urandom_range(99) < 8)
        begin
            send_req(FUNC_W'($urandom_range(3)), TASK_W'($urandom_range(255)),
                     TIME_W'($urandom), PRIO_W'($urandom_range(255)), TIME_W'($urandom));
        end
        else
        begin
            if ($urandom_range(99) < 85)
                send_req(ppd_pkg::FUNC_CLEAR, TASK_W'($urandom_range(255)),
                         TIME_W'($urandom), PRIO_W'($urandom_range(255)),
                         TIME_W'($urandom));
            n_add = $urandom_range(10, 1);
            n_run = $urandom_range(8, 2);
            tick  = ($urandom_range(3) == 0) ? TIME_W'($urandom)
                                             : TIME_W'($urandom_range(50));
            repeat (n_add)
                send_req(ppd_pkg::FUNC_ADD, TASK_W'($urandom_range(255)), rand_period(),
                         rand_prio(), TIME_W'($urandom));
            repeat (n_run)
            begin
                if ($urandom_range(99) < 10)
                    tick = TIME_W'($urandom);
                else
                    tick = tick + TIME_W'($urandom_range(25));
                send_req(ppd_pkg::FUNC_RUN, TASK_W'($urandom_range(255)), TIME_W'($urandom),
                         PRIO_W'($urandom_range(255)), tick);
            end
        end
    endtask

    task automatic test_empty_table();
        send_req(ppd_pkg::FUNC_RUN, 8'd0, 32'd0, 8'd0, TIME_W'($urandom));
        send_req(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_req(ppd_pkg::FUNC_CLEAR, 8'd0, 32'd0, 8'd0, 32'd0);
    endtask

    task automatic test_priority_order();
        send_req(ppd_pkg::FUNC_ADD, 8'd0,   32'd0,          8'd5,   32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd255, 32'hFFFF_FFFF,  8'd255, 32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd17,  32'd3,          8'd5,   32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd42,  32'd1,          8'd0,   32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd99,  32'd10,         8'd128, 32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd7,   32'd0,          8'd5,   32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd200, 32'd2,          8'd255, 32'd0);
        send_req(ppd_pkg::FUNC_ADD, 8'd3,   32'd0,          8'd0,   32'd0);
        send_req(ppd_pkg::FUNC_RUN, 8'd0,   32'd0,          8'd0,   32'd0);
    endtask

    task automatic test_table_full();
        send_req(ppd_pkg::FUNC_ADD, 8'd128, 32'd0, 8'd255, 32'd0);
    endtask

    task automatic test_period_extremes();
        send_req(ppd_pkg::FUNC_RUN, 8'd0, 32'd0, 8'd0, 32'd1);
        send_req(ppd_pkg::FUNC_RUN, 8'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
        send_req(ppd_pkg::FUNC_RUN, 8'd0, 32'd0, 8'd0, 32'd5);
        send_req(ppd_pkg::FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // sink holds off once while runs each dispatch a full table of tasks
    task automatic test_output_backpressure();
        send_req(ppd_pkg::FUNC_CLEAR, 8'd0, 32'd0, 8'd0, 32'd0);
        for (int i = 0; i < TASK_SLOTS; i++)
            send_req(ppd_pkg::FUNC_ADD, TASK_W'(i + 1), 32'd0, PRIO_W'($urandom_range(255)),
                     32'd0);
        hold_req = 1'b1;
        repeat (6)
            send_req(ppd_pkg::FUNC_RUN, 8'd0, 32'd0, 8'd0, TIME_W'($urandom));
    endtask

    task automatic test_random_schedules(input int target);
        int stop_at;
        stop_at = req_count + target;
        while (req_count < stop_at)
            random_schedule();
    endtask

    task automatic test_back_to_back(input int target);
        int stop_at;
        stop_at = req_count + target;
        no_idle = 1'b1;
        while (req_count < stop_at)
            random_schedule();
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = ppd_pkg::FUNC_CLEAR;
        in_ch.task_id      = '0;
        in_ch.period       = '0;
        in_ch.priority_req = '0;
        in_ch.now          = '0;
        out_ch.ready       = 1'b0;
        tbl_count          = 0;
        mismatch_count     = 0;
        req_count          = 0;
        no_idle            = 1'b0;
        hold_req           = 1'b0;
        tick               = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_priority_order();
        test_table_full();
        test_period_extremes();
        test_output_backpressure();
        test_random_schedules(300);
        test_back_to_back(60);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * TASK_SLOTS + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
